/* rtl/core/lwlrs_pkg.sv */
// Shared types and constants for the late window log return share block.
// Used by the datapath modules under rtl/core; depends on nothing.
package lwlrs_pkg;

  localparam int PRICE_W = 32;
  localparam int LOG_W   = 32;
  localparam int SUM_W   = 40;
  localparam int FRAC_W  = 24;
  localparam int BARS_W  = 11;
  localparam int WIN_W   = 10;
  localparam int NUM_W   = 56;   // |tail_sum| << 16
  localparam int DEN_W   = 33;   // |total log return|

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic [0:0] REG_BARS   = 1'b0;
  localparam logic [0:0] REG_WINDOW = 1'b1;

  typedef struct packed {
    logic [LOG_W-1:0] lg;
    logic             ok;
  } log_item_t;

  typedef struct packed {
    logic             full;
    logic             empty;
  } fifo_status_t;

endpackage

/* rtl/core/lwlrs_log.sv */
// Front end: accepts a price beat and turns it into ln(price) in Q8.24.
// Depends on lwlrs_pkg. One squaring per cycle, then a ln2 scale and round.
module lwlrs_log (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                price,
  input  logic                       price_ok,
  output logic                       push,
  output lwlrs_pkg::log_item_t       item,
  input  lwlrs_pkg::fifo_status_t    fstat
);

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_NORM = 6'b000010,
    F_SQR  = 6'b000100,
    F_MUL  = 6'b001000,
    F_RND  = 6'b010000,
    F_PUSH = 6'b100000
  } fstate_t;

  fstate_t     state;
  logic [31:0] x;
  logic [4:0]  msb;
  logic [4:0]  cnt;
  logic [23:0] frac;
  logic        ok;
  logic        neg;
  logic [60:0] prod;
  logic [31:0] lg;

  logic [63:0] sq;
  logic [32:0] y;
  logic signed [5:0]  e;
  logic signed [29:0] l2;
  logic [28:0] mag;
  logic [60:0] rounded;
  logic [31:0] m;

  always_comb begin
    sq      = 64'(x) * 64'(x);
    y       = sq[63:31];
    e       = $signed({1'b0, msb}) - 6'sd16;
    l2      = {e, frac};
    mag     = l2[29] ? 29'(-l2) : 29'(l2);
    rounded = prod + 61'(64'h8000_0000);
    m       = 32'(rounded[60:32]);
  end

  assign in_ready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !fstat.full;
  assign item.lg  = lg;
  assign item.ok  = ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            x   <= price;
            msb <= 5'd31;
            ok  <= price_ok && (price != 32'd0);
            lg  <= '0;
            state <= (price_ok && (price != 32'd0)) ? F_NORM : F_PUSH;
          end
        end
        F_NORM: begin
          if (x[31]) begin
            cnt   <= '0;
            frac  <= '0;
            state <= F_SQR;
          end else if (x[31:24] == 8'd0) begin
            x   <= {x[23:0], 8'd0};
            msb <= msb - 5'd8;
          end else begin
            x   <= {x[30:0], 1'b0};
            msb <= msb - 5'd1;
          end
        end
        F_SQR: begin
          x    <= y[32] ? y[32:1] : y[31:0];
          frac <= {frac[22:0], y[32]};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(lwlrs_pkg::FRAC_W - 1)) state <= F_MUL;
        end
        F_MUL: begin
          prod  <= 61'(mag) * 61'(lwlrs_pkg::LN2_Q32);
          neg   <= l2[29];
          state <= F_RND;
        end
        F_RND: begin
          lg    <= neg ? -m : m;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!fstat.full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/lwlrs_fifo.sv */
// Short queue of log items between the front end and the back end.
// Depends on lwlrs_pkg.
module lwlrs_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lwlrs_pkg::log_item_t     wr_item,
  input  logic                     pop,
  output lwlrs_pkg::log_item_t     rd_item,
  output lwlrs_pkg::fifo_status_t  fstat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lwlrs_pkg::log_item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign fstat.full  = (count == (AW+1)'(DEPTH));
  assign fstat.empty = (count == '0);
  assign rd_item     = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      if (pop)  rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      if (push && !pop) count <= count + (AW+1)'(1);
      else if (pop && !push) count <= count - (AW+1)'(1);
    end
  end

endmodule

/* rtl/core/lwlrs_back.sv */
// Back end: row bookkeeping, tail sum, restoring divide and result register.
// Depends on lwlrs_pkg.
module lwlrs_back #(
  parameter int MAX_BARS = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [10:0]              bars_per_row,
  input  logic [9:0]               window_bars,
  input  lwlrs_pkg::log_item_t     rd_item,
  input  lwlrs_pkg::fifo_status_t  fstat,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              share,
  output logic                     share_valid
);

  localparam int NW = $clog2(MAX_BARS + 1);
  localparam int CW = (NW > 11) ? NW : 11;
  localparam int PW = $clog2(MAX_BARS);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t state;
  logic signed [31:0] first_log, prev_log;
  logic               first_ok, prev_ok;
  logic [PW-1:0]      position;
  logic signed [39:0] tail_sum;
  logic [55:0]        un;
  logic [32:0]        ud;
  logic [32:0]        rem;
  logic [55:0]        q;
  logic [5:0]         cnt;
  logic               neg;
  logic               res_ok;

  logic [CW-1:0] bars_x, n, w, start, t;
  logic signed [31:0] lg, first_now;
  logic          first_ok_now, row_end, add_en, valid_now;
  logic signed [39:0] sum_next;
  logic signed [32:0] total;
  logic [33:0]   sh;
  logic [31:0]   sat;

  always_comb begin
    bars_x = CW'(bars_per_row);
    if (bars_x == '0) n = CW'(1);
    else if (bars_x > CW'(MAX_BARS)) n = CW'(MAX_BARS);
    else n = bars_x;
    w     = CW'(window_bars);
    start = (n > w) ? n - w : CW'(1);
    t     = CW'(position);
    lg    = $signed(rd_item.lg);
    add_en = (t != '0) && (t >= start) && prev_ok && rd_item.ok;
    sum_next = add_en ? tail_sum + 40'(33'(lg) - 33'(prev_log)) : tail_sum;
    first_now    = (t == '0) ? lg : first_log;
    first_ok_now = (t == '0) ? rd_item.ok : first_ok;
    row_end  = ({1'b0, t} + (CW+1)'(1)) >= {1'b0, n};
    total    = 33'(lg) - 33'(first_now);
    valid_now = first_ok_now && rd_item.ok && (total != '0);
    sh = {rem, un[55]};
    if (neg) sat = (q > 56'h8000_0000) ? 32'h8000_0000 : -q[31:0];
    else     sat = (q > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  end

  assign pop = (state == B_IDLE) && !fstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      first_log <= '0;
      first_ok  <= 1'b0;
      prev_log  <= '0;
      prev_ok   <= 1'b0;
      position  <= '0;
      tail_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken beat unless a new one loads this cycle.
      if (out_valid && out_ready && (state != B_DONE)) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (pop) begin
            prev_log <= lg;
            prev_ok  <= rd_item.ok;
            first_log <= first_now;
            first_ok  <= first_ok_now;
            if (!row_end) begin
              position <= position + PW'(1);
              tail_sum <= sum_next;
            end else begin
              position <= '0;
              tail_sum <= '0;
              res_ok <= valid_now;
              neg <= sum_next[39] ^ total[32];
              un  <= {(sum_next[39] ? 40'(-sum_next) : 40'(sum_next)), 16'd0};
              ud  <= total[32] ? 33'(-total) : 33'(total);
              rem <= '0;
              q   <= '0;
              cnt <= '0;
              state <= valid_now ? B_DIV : B_DONE;
            end
          end
        end
        B_DIV: begin
          if (sh >= {1'b0, ud}) begin
            rem <= 33'(sh - {1'b0, ud});
            q   <= {q[54:0], 1'b1};
          end else begin
            rem <= sh[32:0];
            q   <= {q[54:0], 1'b0};
          end
          un  <= {un[54:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(lwlrs_pkg::NUM_W - 1)) state <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            share       <= res_ok ? sat : 32'd0;
            share_valid <= res_ok;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/late_window_log_return_share.sv */
// Top level of the late window log return share block.
// Depends on lwlrs_pkg, lwlrs_log, lwlrs_fifo and lwlrs_back.
//
// Each input beat carries one price (unsigned Q16.16) and its validity flag.
// After bars_per_row prices the block returns one result beat: the sum of
// log returns over the last window_bars steps divided by the log return
// from first to last price, signed Q16.16, saturating; share_valid drops
// (and share is zero) when an end price is invalid or the total is zero.
// A valid price passes the front end as: the accept, leading-zero
// normalization (up to ten shifts until the top bit is set), one squaring
// per fraction bit through one 32x32 multiplier, a ln2 scale, a round and
// a push; invalid prices skip straight from the accept to the push. The
// back end takes one price per cycle while idle with its queue not empty;
// a row end with a valid share adds one-bit restoring division of a 56-bit
// numerator and a load of the result register; an invalid row end adds
// only that load. A four-deep queue between the two lets the front keep
// logging the next row while the back divides, and the result register
// lets the back go on while a result beat waits. Configuration writes take
// effect at once; write only while idle. Row length is held to 1..MAX_BARS.
module late_window_log_return_share #(
  parameter int MAX_BARS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] price
  input  logic [0:0]  s_tuser,   // [0] price_ok
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] share
  output logic [0:0]  m_tuser,   // [0] share_valid
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  logic [10:0] bars_per_row;
  logic [9:0]  window_bars;

  logic                    push, pop;
  lwlrs_pkg::log_item_t    wr_item, rd_item;
  lwlrs_pkg::fifo_status_t fstat;

  // Hold the configuration registers; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      bars_per_row <= 11'd48;
      window_bars  <= 10'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        lwlrs_pkg::REG_BARS:   bars_per_row <= cfg_wdata;
        lwlrs_pkg::REG_WINDOW: window_bars  <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Front end: log of each accepted price.
  lwlrs_log u_log (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .price    (s_tdata),
    .price_ok (s_tuser[0]),
    .push     (push),
    .item     (wr_item),
    .fstat    (fstat)
  );

  // Decouple front and back.
  lwlrs_fifo #(.DEPTH(4)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .fstat   (fstat)
  );

  // Back end: accumulate, divide at row end, drive the result beat.
  lwlrs_back #(.MAX_BARS(MAX_BARS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .bars_per_row (bars_per_row),
    .window_bars  (window_bars),
    .rd_item      (rd_item),
    .fstat        (fstat),
    .pop          (pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .share        (m_tdata),
    .share_valid  (m_tuser[0])
  );

endmodule

/* rtl/core/lwlrs_checker.sv */
// Port-level checks for late_window_log_return_share, bound to the top level.
// Depends on the top level's ports only.
module lwlrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // An invalid result beat carries a zero share.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
    else $error("invalid share beat with nonzero data");

  // The front end works one price at a time: no accept right after an accept.
  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("front end accepted two beats back to back");

  // No result beat straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !m_tvalid)
    else $error("result beat right after reset");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result beat changed while stalled");

endmodule

bind late_window_log_return_share lwlrs_checker u_lwlrs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
